[src/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored while reset is low.
`define APV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, ignored while reset is low.
`define APV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/apv_pkg.sv]
package apv_pkg;

    localparam int CFG_W  = 13;
    localparam int KEPT_W = 13;
    localparam int TOT_W  = CFG_W + 1;

    typedef logic [1:0] t_class;
    typedef logic [3:0] t_reason;

    localparam t_class CLS_OK    = 2'd0;
    localparam t_class CLS_UNSAFE = 2'd1;
    localparam t_class CLS_LIMIT = 2'd2;

    localparam t_reason RSN_OK        = 4'd0;
    localparam t_reason RSN_EMPTY     = 4'd1;
    localparam t_reason RSN_ABSOLUTE  = 4'd2;
    localparam t_reason RSN_BACKSLASH = 4'd3;
    localparam t_reason RSN_DOT_SEG   = 4'd4;
    localparam t_reason RSN_ALIAS     = 4'd5;
    localparam t_reason RSN_BAD_CHAR  = 4'd6;
    localparam t_reason RSN_DEPTH     = 4'd7;
    localparam t_reason RSN_TOO_LONG  = 4'd8;

    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Lower-case device names, first character in the low byte.
    localparam logic [23:0] DEV_CON = 24'h6e6f63;
    localparam logic [23:0] DEV_PRN = 24'h6e7270;
    localparam logic [23:0] DEV_AUX = 24'h787561;
    localparam logic [23:0] DEV_NUL = 24'h6c756e;
    localparam logic [23:0] DEV_COM = 24'h6d6f63;
    localparam logic [23:0] DEV_LPT = 24'h74706c;

    localparam logic [CFG_W-1:0] MAX_SEG_RST = 13'd32;

    // Per-segment tracking state.
    typedef struct packed {
        logic [2:0]  len;
        logic        all_dots;
        logic [31:0] base;
        logic [2:0]  base_len;
        logic        base_dot;
        logic [7:0]  prev;
        logic        bad;
    } t_seg;

    localparam t_seg SEG_CLEAR = '{len: 3'd0, all_dots: 1'b1, base: 32'd0,
                                   base_len: 3'd0, base_dot: 1'b0, prev: 8'd0,
                                   bad: 1'b0};

    // Outcome of closing a segment.
    typedef struct packed {
        t_reason          err;
        logic [TOT_W-1:0] total;
    } t_close;

endpackage

[src/archive_path_validator.sv]
// Channel   | valid          | stall          | payload
// ----------+----------------+----------------+-----------------------------------------
// in        | i_valid        | o_stall        | i_path_byte, i_last_byte, i_empty_path
// out       | o_valid        | i_stall        | o_verdict_class, o_reject_reason,
//           |                |                | o_kept_length
// config    | i_cfg_wr_en    | -              | i_cfg_wr_data (max_segments)
//
// One byte request per cycle while o_stall is low; the verdict shows on o_valid once
// the request carrying the last byte has passed the input register and then the
// result register. The byte step is one pass of flag logic between the two.
// Reset is synchronous, active low; max_segments returns to 32.
// A stalled verdict holds the result register; byte requests keep flowing until
// a second verdict would need the busy result register.
module archive_path_validator #(
    parameter int MAX_PATH_LEN = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [apv_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_path_byte,
    input  logic                           i_last_byte,
    input  logic                           i_empty_path,
    output logic                           o_valid,
    input  logic                           i_stall,
    output apv_pkg::t_class                o_verdict_class,
    output apv_pkg::t_reason               o_reject_reason,
    output logic [apv_pkg::KEPT_W-1:0]     o_kept_length
);
    import apv_pkg::*;

    // Byte counter saturates one past the bound so overlong paths are seen.
    localparam int PW = $clog2(MAX_PATH_LEN + 2);
    localparam logic [PW-1:0] POS_SAT = PW'(MAX_PATH_LEN + 1);

    // Input register
    logic             r_in_vld;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             r_empty;

    // Configuration
    logic [CFG_W-1:0] r_max_seg;

    // Path state
    logic [PW-1:0]    r_pos,   n_pos;
    logic [7:0]       r_first, n_first;
    t_reason          r_err,   n_err;
    logic             r_bs,    n_bs;
    logic             r_abs,   n_abs;
    logic [1:0]       r_run,   n_run;
    logic [TOT_W-1:0] r_tot,   n_tot;
    t_seg             r_seg,   n_seg;
    logic [PW-1:0]    r_end,   n_end;

    // Result register
    logic             r_out_vld;
    t_class           r_cls,   n_cls;
    t_reason          r_rsn,   n_rsn;
    logic [KEPT_W-1:0] r_kept, n_kept;

    logic gives_res;
    logic adv;

    function automatic logic is_dev(input t_seg s);
        logic [23:0] head;
        logic [7:0]  dig;
        logic        r;
        head = s.base[23:0];
        dig  = s.base[31:24];
        r    = 1'b0;
        if (s.base_len == 3'd3) begin
            r = (head == DEV_CON) || (head == DEV_PRN) || (head == DEV_AUX) ||
                (head == DEV_NUL);
        end else if (s.base_len == 3'd4) begin
            r = ((head == DEV_COM) || (head == DEV_LPT)) && (dig >= CH_ONE) &&
                (dig <= CH_NINE);
        end
        return r;
    endfunction

    function automatic t_close close_seg(input t_seg s, input t_reason err,
                                         input logic [TOT_W-1:0] tot,
                                         input logic [CFG_W-1:0] mx);
        t_close c;
        c.err   = err;
        c.total = tot;
        if (err == RSN_OK) begin
            priority if (s.len == 3'd0 || (s.all_dots && s.len <= 3'd2)) begin
                c.err = RSN_DOT_SEG;
            end else if (s.prev == CH_DOT || s.prev == CH_SPACE || is_dev(s)) begin
                c.err = RSN_ALIAS;
            end else if (s.bad) begin
                c.err = RSN_BAD_CHAR;
            end else begin
                c.total = tot + 1'b1;
                if (c.total > {1'b0, mx}) begin
                    c.err = RSN_DEPTH;
                end
            end
        end
        return c;
    endfunction

    function automatic t_seg add_seg(input t_seg s, input logic [7:0] b);
        t_seg       o;
        logic [7:0] low;
        o   = s;
        low = (b >= 8'h41 && b <= 8'h5a) ? (b + 8'h20) : b;
        if (s.len < 3'd7) begin
            o.len = s.len + 3'd1;
        end
        if (b != CH_DOT) begin
            o.all_dots = 1'b0;
        end
        if (!s.base_dot) begin
            if (b == CH_DOT) begin
                o.base_dot = 1'b1;
            end else begin
                if (!s.base_len[2]) begin
                    o.base[8*s.base_len[1:0] +: 8] = s.base[8*s.base_len[1:0] +: 8] | low;
                end
                if (s.base_len < 3'd7) begin
                    o.base_len = s.base_len + 3'd1;
                end
            end
        end
        if (b < CH_SPACE || b == CH_DEL || b == CH_COLON) begin
            o.bad = 1'b1;
        end
        o.prev = b;
        return o;
    endfunction

    // Byte step: one pass from the held byte and the path state
    always_comb begin
        t_close     c;
        logic       is_letter;
        logic [7:0] fold;

        n_pos   = r_pos;
        n_first = r_first;
        n_err   = r_err;
        n_bs    = r_bs;
        n_abs   = r_abs;
        n_run   = r_run;
        n_tot   = r_tot;
        n_seg   = r_seg;
        n_end   = r_end;
        n_cls   = CLS_OK;
        n_rsn   = RSN_OK;
        n_kept  = '0;
        fold      = r_first | 8'h20;
        is_letter = (fold >= 8'h61) && (fold <= 8'h7a);
        c         = '{err: r_err, total: r_tot};

        if (r_pos == '0) begin
            n_first = r_byte;
            if (r_byte == CH_SLASH || r_byte == CH_BSLASH) begin
                n_abs = 1'b1;
            end
        end else if (r_pos == PW'(1)) begin
            if (is_letter && r_byte == CH_COLON) begin
                n_abs = 1'b1;
            end
        end
        if (r_byte == CH_BSLASH) begin
            n_bs = 1'b1;
        end

        if (r_byte == CH_SLASH) begin
            if (r_run == 2'd0) begin
                c     = close_seg(r_seg, r_err, r_tot, r_max_seg);
                n_err = c.err;
                n_tot = c.total;
                n_seg = SEG_CLEAR;
            end
            if (r_run < 2'd2) begin
                n_run = r_run + 2'd1;
            end
        end else begin
            if (r_run[1] && r_err == RSN_OK) begin
                n_err = RSN_DOT_SEG;
            end
            n_run = 2'd0;
            n_seg = add_seg(r_seg, r_byte);
            if (r_pos < POS_SAT) begin
                n_end = r_pos + 1'b1;
            end
        end
        if (r_pos < POS_SAT) begin
            n_pos = r_pos + 1'b1;
        end

        // Final segment closes on a last byte that is not a slash
        if (r_last && r_byte != CH_SLASH) begin
            c     = close_seg(n_seg, n_err, n_tot, r_max_seg);
            n_err = c.err;
            n_tot = c.total;
        end

        priority if (n_pos == POS_SAT) begin
            n_cls = CLS_LIMIT;
            n_rsn = RSN_TOO_LONG;
        end else if (n_abs) begin
            n_cls = CLS_UNSAFE;
            n_rsn = RSN_ABSOLUTE;
        end else if (n_bs) begin
            n_cls = CLS_UNSAFE;
            n_rsn = RSN_BACKSLASH;
        end else if (n_err != RSN_OK) begin
            n_rsn = n_err;
            n_cls = (n_err == RSN_DEPTH) ? CLS_LIMIT : CLS_UNSAFE;
        end else begin
            n_kept = KEPT_W'(n_end);
        end

        if (r_empty) begin
            n_cls  = CLS_UNSAFE;
            n_rsn  = RSN_EMPTY;
            n_kept = '0;
        end
    end

    assign gives_res = r_last || r_empty;
    // A held request moves on unless it needs a result slot that is still full
    assign adv       = r_in_vld && (!gives_res || !r_out_vld || !i_stall);
    assign o_stall   = r_in_vld && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_max_seg <= MAX_SEG_RST;
            r_pos     <= '0;
            r_first   <= '0;
            r_err     <= RSN_OK;
            r_bs      <= 1'b0;
            r_abs     <= 1'b0;
            r_run     <= 2'd0;
            r_tot     <= '0;
            r_seg     <= SEG_CLEAR;
            r_end     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_seg <= i_cfg_wr_data;
            end

            if (i_valid && !o_stall) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end

            if (adv) begin
                if (gives_res) begin
                    // Path finished: back to the reset state
                    r_pos   <= '0;
                    r_first <= '0;
                    r_err   <= RSN_OK;
                    r_bs    <= 1'b0;
                    r_abs   <= 1'b0;
                    r_run   <= 2'd0;
                    r_tot   <= '0;
                    r_seg   <= SEG_CLEAR;
                    r_end   <= '0;
                end else begin
                    r_pos   <= n_pos;
                    r_first <= n_first;
                    r_err   <= n_err;
                    r_bs    <= n_bs;
                    r_abs   <= n_abs;
                    r_run   <= n_run;
                    r_tot   <= n_tot;
                    r_seg   <= n_seg;
                    r_end   <= n_end;
                end
            end

            if (adv && gives_res) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte  <= i_path_byte;
            r_last  <= i_last_byte;
            r_empty <= i_empty_path;
        end
        if (adv && gives_res) begin
            r_cls  <= n_cls;
            r_rsn  <= n_rsn;
            r_kept <= n_kept;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_verdict_class = r_cls;
    assign o_reject_reason = r_rsn;
    assign o_kept_length   = r_kept;

endmodule

[src/apv_checker.sv]
`include "assert_macros.svh"

module apv_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input apv_pkg::t_class            o_verdict_class,
    input apv_pkg::t_reason           o_reject_reason,
    input logic [apv_pkg::KEPT_W-1:0] o_kept_length
);
    import apv_pkg::*;

    // A verdict held back by the sink stays put
    `APV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_verdict_class) && $stable(o_reject_reason) && $stable(o_kept_length),
        "stalled verdict changed")

    // Requests are only held back by a verdict the sink is stalling
    `APV_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall,
        o_valid && i_stall,
        "request stalled with the result side free")

    // Accepted iff no reason
    `APV_ASSERT_NOW(a_ok_match, i_clk, i_rst_n, o_valid,
        (o_verdict_class == CLS_OK) == (o_reject_reason == RSN_OK),
        "class and reason disagree on acceptance")

    // Limit class only for depth or length
    `APV_ASSERT_NOW(a_limit_match, i_clk, i_rst_n, o_valid,
        (o_verdict_class == CLS_LIMIT) ==
        (o_reject_reason == RSN_DEPTH || o_reject_reason == RSN_TOO_LONG),
        "limit class with wrong reason")

    // Rejected paths report no length; reasons stay in range
    `APV_ASSERT_NOW(a_rej_len, i_clk, i_rst_n, o_valid && o_reject_reason != RSN_OK,
        o_kept_length == '0 && o_reject_reason <= RSN_TOO_LONG,
        "rejected verdict with length or bad reason")

endmodule

bind archive_path_validator apv_checker u_apv_checker (.*);

[tb/archive_path_validator_tb.sv]
`timescale 1ns / 1ps

module archive_path_validator_tb;
    import apv_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int PATH_LIMIT   = 4096;   // matches the default MAX_PATH_LEN
    localparam int QUIET_LIMIT  = 1000;   // cycles with no handshake on either side
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 165;    // with the directed rows, about 1150 requests
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;      // wait after the drain for stray verdicts

    // One verdict as the block reports it.
    typedef struct packed {
        t_class            cls;
        t_reason           rsn;
        logic [KEPT_W-1:0] kept;
    } t_verdict;

    // Directed row: a path (text, then 'a' padding up to fill bytes), or an
    // empty-path request. open_end leaves the path without its last-byte mark.
    typedef struct {
        string   text;
        int      fill;
        bit      is_empty;
        bit      open_end;
        int      cfg;       // max_segments to write first, -1 for none
        bit      typed;     // expected verdict given in the row
        t_class  cls;
        t_reason rsn;
        int      kept;
    } t_dir_row;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wr_data = '0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic [7:0]        i_path_byte   = '0;
    logic              i_last_byte   = 1'b0;
    logic              i_empty_path  = 1'b0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    t_class            o_verdict_class;
    t_reason           o_reject_reason;
    logic [KEPT_W-1:0] o_kept_length;

    archive_path_validator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_path_byte     (i_path_byte),
        .i_last_byte     (i_last_byte),
        .i_empty_path    (i_empty_path),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_verdict_class (o_verdict_class),
        .o_reject_reason (o_reject_reason),
        .o_kept_length   (o_kept_length)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    t_verdict   pending_verdicts[$];
    logic [7:0] path_bytes[$];
    t_dir_row   dir_rows[$];
    int         fail_count    = 0;
    int         requests_sent = 0;
    int         quiet_cycles  = 0;
    int         stall_left    = 0;
    bit         tx_idle_en    = 1'b1;
    bit         rx_idle_en    = 1'b1;

    // ------------------------------------------------------------------
    // Path checker model: own copy of the register and the per-path state.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] depth_limit = MAX_SEG_RST;
    int               path_pos;       // bytes seen, saturates at PATH_LIMIT + 1
    logic [7:0]       lead_byte;
    t_reason          held_err;       // first segment-level error, RSN_OK if none
    bit               bslash_seen;
    bit               abs_seen;
    int               slash_run;      // saturates at 2
    int               seg_count;
    int               kept_end;       // length up to the last non-slash byte
    t_seg             seg;

    function automatic bit ascii_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic void clear_path_model();
        path_pos    = 0;
        lead_byte   = '0;
        held_err    = RSN_OK;
        bslash_seen = 1'b0;
        abs_seen    = 1'b0;
        slash_run   = 0;
        seg_count   = 0;
        kept_end    = 0;
        seg         = SEG_CLEAR;
    endfunction

    // Reserved device base: con/prn/aux/nul, or com/lpt plus one digit 1-9.
    function automatic bit seg_is_device();
        logic [23:0] head;
        logic [7:0]  digit;
        head  = seg.base[23:0];
        digit = seg.base[31:24];
        if (seg.base_len == 3'd3)
            return head == DEV_CON || head == DEV_PRN || head == DEV_AUX || head == DEV_NUL;
        if (seg.base_len == 3'd4)
            return (head == DEV_COM || head == DEV_LPT) && digit >= CH_ONE && digit <= CH_NINE;
        return 1'b0;
    endfunction

    // Segment checks in rank order; only the first error of the path is kept.
    function automatic void close_seg();
        if (held_err == RSN_OK) begin
            if (seg.len == 3'd0 || (seg.all_dots && seg.len <= 3'd2)) begin
                held_err = RSN_DOT_SEG;
            end else if (seg.prev == CH_DOT || seg.prev == CH_SPACE || seg_is_device()) begin
                held_err = RSN_ALIAS;
            end else if (seg.bad) begin
                held_err = RSN_BAD_CHAR;
            end else begin
                seg_count++;
                if (seg_count > int'(depth_limit))
                    held_err = RSN_DEPTH;
            end
        end
        seg = SEG_CLEAR;
    endfunction

    function automatic void add_seg_byte(logic [7:0] b);
        logic [7:0] low;
        if (seg.len < 3'd7)
            seg.len++;
        if (b != CH_DOT)
            seg.all_dots = 1'b0;
        if (!seg.base_dot) begin
            if (b == CH_DOT) begin
                seg.base_dot = 1'b1;
            end else begin
                low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                if (seg.base_len < 3'd4)
                    seg.base[8*seg.base_len +: 8] = low;
                if (seg.base_len < 3'd7)
                    seg.base_len++;
            end
        end
        if (b < CH_SPACE || b == CH_DEL || b == CH_COLON)
            seg.bad = 1'b1;
        seg.prev = b;
    endfunction

    // Steps the model by one request; returns 1 when a verdict is due.
    function automatic bit predict_verdict(input logic [7:0] b, input bit last,
                                           input bit empty, output t_verdict v);
        v.cls  = CLS_OK;
        v.rsn  = RSN_OK;
        v.kept = '0;
        if (empty) begin
            // discards any unfinished path, whatever the last-byte mark says
            clear_path_model();
            v.cls = CLS_UNSAFE;
            v.rsn = RSN_EMPTY;
            return 1'b1;
        end
        if (path_pos == 0) begin
            lead_byte = b;
            if (b == CH_SLASH || b == CH_BSLASH)
                abs_seen = 1'b1;
        end else if (path_pos == 1) begin
            if (ascii_letter(lead_byte) && b == CH_COLON)
                abs_seen = 1'b1;
        end
        if (b == CH_BSLASH)
            bslash_seen = 1'b1;
        if (b == CH_SLASH) begin
            if (slash_run == 0)
                close_seg();
            if (slash_run < 2)
                slash_run++;
        end else begin
            // a run of two or more slashes followed by more path is an empty segment
            if (slash_run >= 2 && held_err == RSN_OK)
                held_err = RSN_DOT_SEG;
            slash_run = 0;
            add_seg_byte(b);
            if (path_pos < PATH_LIMIT + 1)
                kept_end = path_pos + 1;
        end
        if (path_pos < PATH_LIMIT + 1)
            path_pos++;
        if (!last)
            return 1'b0;

        if (b != CH_SLASH)
            close_seg();
        if (path_pos > PATH_LIMIT) begin
            v.cls = CLS_LIMIT;
            v.rsn = RSN_TOO_LONG;
        end else if (abs_seen) begin
            v.cls = CLS_UNSAFE;
            v.rsn = RSN_ABSOLUTE;
        end else if (bslash_seen) begin
            v.cls = CLS_UNSAFE;
            v.rsn = RSN_BACKSLASH;
        end else if (held_err != RSN_OK) begin
            v.rsn = held_err;
            v.cls = (held_err == RSN_DEPTH) ? CLS_LIMIT : CLS_UNSAFE;
        end else begin
            v.kept = KEPT_W'(kept_end);
        end
        clear_path_model();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Verdict side: check against the oldest expectation, stall in bursts.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        t_verdict got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.cls  = o_verdict_class;
                got.rsn  = o_reject_reason;
                got.kept = o_kept_length;
                if (pending_verdicts.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: verdict with none pending: cls %0d rsn %0d kept %0d",
                                 $realtime, got.cls, got.rsn, got.kept);
                    fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.cls !== want.cls || got.rsn !== want.rsn ||
                        got.kept !== want.kept) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: want cls/rsn/kept %0d/%0d/%0d, got %0d/%0d/%0d",
                                     $realtime, want.cls, want.rsn, want.kept,
                                     got.cls, got.rsn, got.kept);
                        fail_count++;
                    end
                end
            end
            // stall bursts, started at random and counted down in stall_left
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: too long with no request and no verdict moving.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
                $display("** archive_path_validator: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drives one request and holds it until taken; the model steps on acceptance.
    // A typed verdict, where given, replaces the model's in the expectation queue.
    task automatic send_request(input logic [7:0] b, input bit last, input bit empty,
                                input bit typed, input t_verdict typed_v);
        t_verdict v;
        i_valid      <= 1'b1;
        i_path_byte  <= b;
        i_last_byte  <= last;
        i_empty_path <= empty;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        requests_sent++;
        if (predict_verdict(b, last, empty, v))
            pending_verdicts.insert(pending_verdicts.size(), typed ? typed_v : v);
    endtask

    // A gap in the requests now and then; the payload is scrambled while idle.
    task automatic sender_pause();
        int n;
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 17);
            i_valid      <= 1'b0;
            i_path_byte  <= 8'($urandom);
            i_last_byte  <= 1'($urandom);
            i_empty_path <= 1'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_empty(input bit last, input bit typed, input t_verdict typed_v);
        send_request(8'($urandom_range(0, 255)), last, 1'b1, typed, typed_v);
        sender_pause();
    endtask

    task automatic send_path(input bit open_end, input bit typed, input t_verdict typed_v);
        int last_idx;
        last_idx = path_bytes.size() - 1;
        for (int i = 0; i <= last_idx; i++) begin
            send_request(path_bytes[i], (i == last_idx) && !open_end, 1'b0, typed, typed_v);
            sender_pause();
        end
    endtask

    // Register writes only with the block idle: every verdict in, pipeline empty.
    task automatic write_max_segments(input int value);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        depth_limit = CFG_W'(value);
    endtask

    // ------------------------------------------------------------------
    // Random path generation
    // ------------------------------------------------------------------
    function automatic void append_byte(logic [7:0] b);
        path_bytes.insert(path_bytes.size(), b);
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if (ascii_letter(c) && $urandom_range(0, 1) == 1)
            return c ^ 8'h20;
        return c;
    endfunction

    // Ordinary segment byte: never a separator, colon or control.
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: c = flip_case(8'($urandom_range("a", "z")));
            6:       c = 8'($urandom_range("0", "9"));
            7:       c = ($urandom_range(0, 2) == 0) ? CH_DOT : 8'($urandom_range("-", "."));
            8:       c = 8'($urandom_range(128, 255));
            default: begin
                do
                    c = 8'($urandom_range(8'h21, 8'h7e));
                while (c == CH_SLASH || c == CH_BSLASH || c == CH_COLON);
            end
        endcase
        return c;
    endfunction

    function automatic void push_plain(int n);
        for (int i = 0; i < n; i++)
            append_byte(plain_byte());
    endfunction

    function automatic void build_segment();
        int    kind;
        int    pick;
        string dev;
        kind = $urandom_range(0, 99);
        if (kind < 72) begin
            push_plain($urandom_range(1, 10));
        end else if (kind < 80) begin
            // device names, with and without digit, extension or extra byte
            case ($urandom_range(0, 5))
                0: dev = "con";
                1: dev = "prn";
                2: dev = "aux";
                3: dev = "nul";
                4: dev = "com";
                default: dev = "lpt";
            endcase
            for (int i = 0; i < dev.len(); i++)
                append_byte(flip_case(dev[i]));
            pick = $urandom_range(0, 10);
            if (pick < 10)
                append_byte(8'("0" + pick));
            if ($urandom_range(0, 6) == 0)
                push_plain(1);
            if ($urandom_range(0, 1) == 1) begin
                append_byte(CH_DOT);
                push_plain($urandom_range(1, 3));
            end
        end else if (kind < 86) begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
                append_byte(CH_DOT);
        end else if (kind < 92) begin
            push_plain($urandom_range(1, 6));
            append_byte(($urandom_range(0, 1) == 1) ? CH_DOT : CH_SPACE);
        end else begin
            push_plain($urandom_range(1, 6));
            pick = $urandom_range(0, 9);
            path_bytes.insert($urandom_range(0, path_bytes.size()),
                              (pick < 3) ? CH_COLON :
                              (pick == 3) ? CH_DEL : 8'($urandom_range(0, 31)));
        end
    endfunction

    // Mostly well-formed paths with a sprinkling of faults; some raw noise.
    function automatic void build_random_path();
        int r;
        path_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 7) begin
            for (int i = $urandom_range(1, 8); i > 0; i--)
                append_byte(8'($urandom_range(0, 255)));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            append_byte(CH_SLASH);
        end else if (r < 5) begin
            append_byte(CH_BSLASH);
        end else if (r < 8) begin
            append_byte(flip_case(8'($urandom_range("a", "z"))));
            append_byte(CH_COLON);
        end
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
            build_segment();
            if (i > 1) begin
                append_byte(CH_SLASH);
                if ($urandom_range(0, 29) == 0)
                    append_byte(CH_SLASH);
            end
        end
        if ($urandom_range(0, 29) == 0)
            path_bytes.insert($urandom_range(0, path_bytes.size()), CH_BSLASH);
        if ($urandom_range(0, 6) == 0)
            for (int i = $urandom_range(1, 3); i > 0; i--)
                append_byte(CH_SLASH);
    endfunction

    function automatic void add_row(string text, int fill, bit is_empty, bit open_end,
                                    int cfg, bit typed, t_class cls, t_reason rsn,
                                    int kept);
        t_dir_row row;
        row.text     = text;
        row.fill     = fill;
        row.is_empty = is_empty;
        row.open_end = open_end;
        row.cfg      = cfg;
        row.typed    = typed;
        row.cls      = cls;
        row.rsn      = rsn;
        row.kept     = kept;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_verdict tv;
        int       phase_start;
        int       r;
        int       phase_cfg[PHASE_COUNT];

        // text, fill, empty, open, cfg, typed, class, reason, kept
        add_row("",         0, 1, 0, -1, 1, CLS_UNSAFE, RSN_EMPTY,     0);
        add_row("a",        0, 0, 0, -1, 1, CLS_OK,     RSN_OK,        1);
        add_row("/abc",     0, 0, 0, -1, 1, CLS_UNSAFE, RSN_ABSOLUTE,  0);
        add_row("\\abc",    0, 0, 0, -1, 1, CLS_UNSAFE, RSN_ABSOLUTE,  0);
        add_row("C:x",      0, 0, 0, -1, 1, CLS_UNSAFE, RSN_ABSOLUTE,  0);
        add_row("a\\b",     0, 0, 0, -1, 1, CLS_UNSAFE, RSN_BACKSLASH, 0);
        add_row("a//b",     0, 0, 0, -1, 1, CLS_UNSAFE, RSN_DOT_SEG,   0);
        add_row("./a",      0, 0, 0, -1, 1, CLS_UNSAFE, RSN_DOT_SEG,   0);
        add_row("a/../b",   0, 0, 0, -1, 1, CLS_UNSAFE, RSN_DOT_SEG,   0);
        add_row("...",      0, 0, 0, -1, 0, CLS_OK,     RSN_OK,        0);
        add_row("a/b.",     0, 0, 0, -1, 1, CLS_UNSAFE, RSN_ALIAS,     0);
        add_row("a /b",     0, 0, 0, -1, 1, CLS_UNSAFE, RSN_ALIAS,     0);
        add_row("CON",      0, 0, 0, -1, 1, CLS_UNSAFE, RSN_ALIAS,     0);
        add_row("lpt9.txt", 0, 0, 0, -1, 1, CLS_UNSAFE, RSN_ALIAS,     0);
        add_row("Com0",     0, 0, 0, -1, 0, CLS_OK,     RSN_OK,        0);
        add_row("aux1/x",   0, 0, 0, -1, 0, CLS_OK,     RSN_OK,        0);
        add_row("ab:c",     0, 0, 0, -1, 1, CLS_UNSAFE, RSN_BAD_CHAR,  0);
        add_row("ab\177",   0, 0, 0, -1, 1, CLS_UNSAFE, RSN_BAD_CHAR,  0);
        add_row("x\001y",   0, 0, 0, -1, 1, CLS_UNSAFE, RSN_BAD_CHAR,  0);
        add_row("\377",     0, 0, 0, -1, 0, CLS_OK,     RSN_OK,        0);
        add_row("dir/sub//",0, 0, 0, -1, 1, CLS_OK,     RSN_OK,        7);
        // unfinished path dropped by an empty-path request without last mark
        add_row("ab",       0, 0, 1, -1, 0, CLS_OK,     RSN_OK,        0);
        add_row("",         0, 1, 1, -1, 1, CLS_UNSAFE, RSN_EMPTY,     0);
        add_row("a",        0, 0, 0,  0, 1, CLS_LIMIT,  RSN_DEPTH,     0);
        add_row("a/b",      0, 0, 0,  1, 1, CLS_LIMIT,  RSN_DEPTH,     0);
        add_row("a/b/c",    0, 0, 0,  2, 0, CLS_OK,     RSN_OK,        0);
        add_row("a/b/c",    0, 0, 0, 4096, 0, CLS_OK,   RSN_OK,        0);

        clear_path_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg >= 0)
                write_max_segments(dir_rows[i].cfg);
            tv.cls  = dir_rows[i].cls;
            tv.rsn  = dir_rows[i].rsn;
            tv.kept = KEPT_W'(dir_rows[i].kept);
            if (dir_rows[i].is_empty) begin
                send_empty(!dir_rows[i].open_end, dir_rows[i].typed, tv);
            end else begin
                path_bytes.delete();
                for (int k = 0; k < dir_rows[i].text.len(); k++)
                    append_byte(dir_rows[i].text[k]);
                while (path_bytes.size() < dir_rows[i].fill)
                    append_byte("a");
                send_path(dir_rows[i].open_end, dir_rows[i].typed, tv);
            end
        end

        // Random phases, each under its own depth limit; the last has no idling.
        phase_cfg = '{4096, 0, 1, 3, 0, 32};
        phase_cfg[4] = $urandom_range(2, 8);
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_max_segments(phase_cfg[p]);
            if (p == PHASE_COUNT - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en <= 1'b0;
            end else begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en <= ($urandom_range(0, 3) != 0);
            end
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send_empty(1'($urandom), 1'b0, tv);
                end else if (r < 5) begin
                    build_random_path();
                    send_path(1'b1, 1'b0, tv);
                    send_empty(1'($urandom), 1'b0, tv);
                end else begin
                    build_random_path();
                    send_path(1'b0, 1'b0, tv);
                end
            end
        end

        // Drain: everything in, then a wait of DRAIN_CYCLES for stray verdicts.
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("** archive_path_validator: PASSED **");
        else
            $display("** archive_path_validator: FAILED **");
        $finish;
    end

endmodule
